/* rtl/mgsf_pkg.sv */
// Shared widths, register indexes and codes for the masked gradient shine fill core.
package mgsf_pkg;

  localparam int PIX_W    = 8;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 10;
  localparam int HGT_W    = 11;
  localparam int SHINE_W  = 11;
  localparam int NIB_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  // Blend operands: hue operand reaches 21 (five bits); quotient stays below 32.
  localparam int OPD_W = 5;
  localparam int QUO_W = 5;
  // Numerator (D - t) * p + t * q stays below 30 * 2047.
  localparam int NUM_W = 16;

  // Input regs, blend setup, numerator, one stage per quotient bit, output reg.
  localparam int PIPE_DEPTH = 4 + QUO_W;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_COLOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_ODD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHINE_START = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHINE_INT   = 3'd6;

  localparam logic [NIB_W-1:0] LUMA_MAX  = 4'hF;
  localparam logic [OPD_W-1:0] HUE_RING  = 5'd15;
  localparam logic [NIB_W-1:0] HUE_SPAN  = 4'd7;

  // How the hue quotient is mapped back onto the palette.
  typedef enum logic [1:0] {
    HUE_PLAIN,  // lower hue is white: quotient is the hue
    HUE_ADD1,   // short way round: quotient + 1
    HUE_WRAP    // wrap across hue 15: (quotient mod 15) + 1
  } hue_mode_e;

endpackage

/* rtl/masked_gradient_shine_fill_core.sv */
// Masked vertical gradient fill with diagonal shine highlight, deep pipeline top level.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------------
//  pixel   | start, busy, pixel_in_i, column_i,        | taken when start & !busy
//          | row_offset_i                              |
//  result  | done_o, pixel_out_o, write_pixel_o        | one-cycle strobe, no stall
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i,    | written when valid & ready
//          | cfg_data_i                                |
//
// One word per cycle in, one word per cycle out; each result passes the capture, blend
// setup, numerator, divider and output registers in turn. The depth is set by the row-ratio
// divider, which resolves one quotient bit per stage for hue and luma side by side.
// busy stays low and cfg_ready_o stays high; the result side cannot stall, so the
// pipeline simply advances every cycle.
// Reset clears the valid bits and the config registers (rect_height to 1).
module masked_gradient_shine_fill_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mgsf_pkg::PIX_W-1:0]    pixel_in_i,
  input  logic [mgsf_pkg::COL_W-1:0]    column_i,
  input  logic [mgsf_pkg::ROW_W-1:0]    row_offset_i,
  output logic                          done_o,
  output logic [mgsf_pkg::PIX_W-1:0]    pixel_out_o,
  output logic                          write_pixel_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mgsf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mgsf_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import mgsf_pkg::*;

  localparam int SC_W = SHINE_W + 2;  // signed shine column and distance

  typedef struct packed {
    logic                 match;
    logic [PIX_W-1:0]     pix;
    logic [NIB_W-1:0]     glow;
    hue_mode_e            mode;
    logic [HGT_W-1:0]     dvs;
    logic [NUM_W-1:0]     rem_h;
    logic [NUM_W-1:0]     rem_l;
    logic [QUO_W-1:0]     quo_h;
    logic [QUO_W-1:0]     quo_l;
  } div_stage_t;

  // ---------------------------------------------------------------- config
  logic [PIX_W-1:0]   color_start_q, color_end_q, mask_color_q;
  logic [HGT_W-1:0]   rect_height_q;
  logic               top_odd_q;
  logic [SHINE_W-1:0] shine_start_q;
  logic [NIB_W-1:0]   shine_int_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_start_q <= '0;
      color_end_q   <= '0;
      mask_color_q  <= '0;
      rect_height_q <= HGT_W'(1);
      top_odd_q     <= 1'b0;
      shine_start_q <= '0;
      shine_int_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COLOR_START: color_start_q <= cfg_data_i[PIX_W-1:0];
        REG_COLOR_END:   color_end_q   <= cfg_data_i[PIX_W-1:0];
        REG_MASK_COLOR:  mask_color_q  <= cfg_data_i[PIX_W-1:0];
        REG_RECT_HEIGHT: rect_height_q <= cfg_data_i[HGT_W-1:0];
        REG_TOP_ODD:     top_odd_q     <= cfg_data_i[0];
        REG_SHINE_START: shine_start_q <= cfg_data_i[SHINE_W-1:0];
        REG_SHINE_INT:   shine_int_q   <= cfg_data_i[NIB_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic             v1_q;
  logic [PIX_W-1:0] pix1_q;
  logic [COL_W-1:0] col1_q;
  logic [ROW_W-1:0] row1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    pix1_q <= pixel_in_i;
    col1_q <= column_i;
    row1_q <= row_offset_i;
  end

  // ---------------------------------------------------------------- stage 2: blend setup
  logic [HGT_W-1:0]  dvs_d, row_ext, rr_d;
  logic [NIB_W-1:0]  hue_a, hue_b, hue_lo, hue_hi, lo_m1, hi_m1;
  logic              hue_swap;
  logic [OPD_W-1:0]  hp_d, hq_d;
  logic [HGT_W-1:0]  ht_d;
  hue_mode_e         mode_d;
  logic [ROW_W:0]    row_par;
  logic [ROW_W-1:0]  half_row;
  logic [SC_W-1:0]   shine_col, col_diff, adist;
  logic [NIB_W-1:0]  glow_d;

  always_comb begin
    dvs_d   = (rect_height_q <= HGT_W'(1)) ? HGT_W'(1) : rect_height_q - HGT_W'(1);
    row_ext = HGT_W'(row1_q);
    // Height of one or zero: ratio is zero; rows past the bottom clamp to it.
    if (rect_height_q <= HGT_W'(1)) rr_d = '0;
    else                            rr_d = (row_ext > dvs_d) ? dvs_d : row_ext;

    hue_a    = color_start_q[PIX_W-1:NIB_W];
    hue_b    = color_end_q[PIX_W-1:NIB_W];
    hue_swap = hue_a > hue_b;
    hue_lo   = hue_swap ? hue_b : hue_a;
    hue_hi   = hue_swap ? hue_a : hue_b;
    ht_d     = hue_swap ? dvs_d - rr_d : rr_d;
    lo_m1    = hue_lo - NIB_W'(1);
    hi_m1    = hue_hi - NIB_W'(1);
    if (hue_lo == '0) begin
      mode_d = HUE_PLAIN;
      hp_d   = '0;
      hq_d   = OPD_W'(hue_hi);
    end else if ((hi_m1 - lo_m1) > HUE_SPAN) begin
      // shorter way round the ring crosses from hue 15 back to hue 1
      mode_d = HUE_WRAP;
      hp_d   = OPD_W'(lo_m1) + HUE_RING;
      hq_d   = OPD_W'(hi_m1);
    end else begin
      mode_d = HUE_ADD1;
      hp_d   = OPD_W'(lo_m1);
      hq_d   = OPD_W'(hi_m1);
    end

    // Shine column drifts left one step every second absolute row.
    row_par   = (ROW_W+1)'(row1_q) + (ROW_W+1)'(top_odd_q);
    half_row  = row_par[ROW_W:1];
    shine_col = SC_W'(shine_start_q) - SC_W'(half_row);
    col_diff  = shine_col - SC_W'(col1_q);
    adist     = col_diff[SC_W-1] ? (~col_diff + SC_W'(1)) : col_diff;
    if (shine_start_q == '0)                  glow_d = '0;
    else if (adist < SC_W'(shine_int_q))      glow_d = shine_int_q - adist[NIB_W-1:0];
    else                                      glow_d = '0;
  end

  logic             v2_q;
  logic             match2_q;
  logic [PIX_W-1:0] pix2_q;
  logic [NIB_W-1:0] glow2_q;
  hue_mode_e        mode2_q;
  logic [HGT_W-1:0] dvs2_q, ht2_q, lt2_q;
  logic [OPD_W-1:0] hp2_q, hq2_q, lp2_q, lq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    match2_q <= (pix1_q == mask_color_q);
    pix2_q   <= pix1_q;
    glow2_q  <= glow_d;
    mode2_q  <= mode_d;
    dvs2_q   <= dvs_d;
    ht2_q    <= ht_d;
    lt2_q    <= rr_d;
    hp2_q    <= hp_d;
    hq2_q    <= hq_d;
    lp2_q    <= OPD_W'(color_start_q[NIB_W-1:0]);
    lq2_q    <= OPD_W'(color_end_q[NIB_W-1:0]);
  end

  // ---------------------------------------------------------------- stage 3: numerators
  div_stage_t          div_d [0:QUO_W];
  div_stage_t          div_q [0:QUO_W];
  logic [QUO_W:0]      dv_q;
  logic [HGT_W-1:0]    hdt, ldt;
  logic [NUM_W-1:0]    step_sub [0:QUO_W-1];

  // ---------------------------------------------------------------- divider: one bit a stage
  always_comb begin
    hdt = dvs2_q - ht2_q;
    ldt = dvs2_q - lt2_q;
    div_d[0].match = match2_q;
    div_d[0].pix   = pix2_q;
    div_d[0].glow  = glow2_q;
    div_d[0].mode  = mode2_q;
    div_d[0].dvs   = dvs2_q;
    div_d[0].rem_h = NUM_W'(hdt) * NUM_W'(hp2_q) + NUM_W'(ht2_q) * NUM_W'(hq2_q);
    div_d[0].rem_l = NUM_W'(ldt) * NUM_W'(lp2_q) + NUM_W'(lt2_q) * NUM_W'(lq2_q);
    div_d[0].quo_h = '0;
    div_d[0].quo_l = '0;
    for (int k = 0; k < QUO_W; k++) begin
      div_d[k+1]  = div_q[k];
      step_sub[k] = NUM_W'(div_q[k].dvs) << (QUO_W - 1 - k);
      if (div_q[k].rem_h >= step_sub[k]) begin
        div_d[k+1].rem_h                = div_q[k].rem_h - step_sub[k];
        div_d[k+1].quo_h[QUO_W - 1 - k] = 1'b1;
      end
      if (div_q[k].rem_l >= step_sub[k]) begin
        div_d[k+1].rem_l                = div_q[k].rem_l - step_sub[k];
        div_d[k+1].quo_l[QUO_W - 1 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else         dv_q <= {dv_q[QUO_W-1:0], v2_q};
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= QUO_W; k++) div_q[k] <= div_d[k];
  end

  // ---------------------------------------------------------------- output stage
  div_stage_t       fin;
  logic [NIB_W-1:0] hue_f;
  logic [QUO_W-1:0] wrap_q;
  logic [NIB_W:0]   luma_sum;
  logic [NIB_W-1:0] luma_f;
  logic [PIX_W-1:0] pixel_out_d;

  always_comb begin
    fin    = div_q[QUO_W];
    wrap_q = (fin.quo_h >= HUE_RING) ? fin.quo_h - HUE_RING : fin.quo_h;
    case (fin.mode)
      HUE_PLAIN: hue_f = fin.quo_h[NIB_W-1:0];
      HUE_ADD1:  hue_f = fin.quo_h[NIB_W-1:0] + NIB_W'(1);
      HUE_WRAP:  hue_f = wrap_q[NIB_W-1:0] + NIB_W'(1);
      default:   hue_f = fin.quo_h[NIB_W-1:0];
    endcase
    luma_sum    = (NIB_W+1)'(fin.quo_l[NIB_W-1:0]) + (NIB_W+1)'(fin.glow);
    luma_f      = luma_sum[NIB_W] ? LUMA_MAX : luma_sum[NIB_W-1:0];
    pixel_out_d = fin.match ? {hue_f, luma_f} : fin.pix;
  end

  logic             done_q, write_q;
  logic [PIX_W-1:0] pixel_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      write_q <= 1'b0;
    end else begin
      done_q  <= dv_q[QUO_W];
      write_q <= dv_q[QUO_W] && fin.match;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_out_q <= pixel_out_d;
  end

  assign done_o        = done_q;
  assign write_pixel_o = write_q;
  assign pixel_out_o   = pixel_out_q;

endmodule

/* rtl/mgsf_checker.sv */
// Port-level checks for the masked gradient shine fill core, with its bind.
module mgsf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic [mgsf_pkg::PIX_W-1:0]     pixel_in_i,
  input logic                           done_o,
  input logic [mgsf_pkg::PIX_W-1:0]     pixel_out_o,
  input logic                           write_pixel_o
);
  import mgsf_pkg::*;

  // every result word comes from a word taken a fixed depth earlier
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result strobe without a matching accepted word");

  // an unmasked pixel comes back untouched
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !write_pixel_o |-> pixel_out_o == $past(pixel_in_i, PIPE_DEPTH))
    else $error("unmasked pixel altered");

  // write flag only rides on a result strobe
  a_write_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_pixel_o |-> done_o)
    else $error("write flag outside a result cycle");

endmodule

bind masked_gradient_shine_fill_core mgsf_checker u_mgsf_checker (.*);

/* dv/masked_gradient_shine_fill_core_test.sv */
// Self-checking testbench for the masked gradient shine fill core.
module masked_gradient_shine_fill_core_test;
  import mgsf_pkg::*;

  // One result word as the core reports it.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             wr;
  } fill_word_t;

  // Directed stimulus: either a register write or a pixel word, with an
  // optional hand-computed expectation.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic [PIX_W-1:0]     pix;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    bit                   typed;
    fill_word_t           want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [PIX_W-1:0]     pixel_in_i = '0;
  logic [COL_W-1:0]     column_i = '0;
  logic [ROW_W-1:0]     row_offset_i = '0;
  logic                 done_o;
  logic [PIX_W-1:0]     pixel_out_o;
  logic                 write_pixel_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  // Local copy of the register file, kept in step with every write.
  logic [PIX_W-1:0]   color_start_q = '0;
  logic [PIX_W-1:0]   color_end_q   = '0;
  logic [PIX_W-1:0]   mask_q        = '0;
  logic [HGT_W-1:0]   height_q      = 11'd1;
  logic               top_odd_q     = 1'b0;
  logic [SHINE_W-1:0] shine_q       = '0;
  logic [NIB_W-1:0]   glow_peak_q   = '0;

  fill_word_t pending_fills[$];
  stim_row_t  stim_rows[$];
  int         errors = 0;
  bit         burst = 1'b0;   // pick_gap adds no gaps while set

  masked_gradient_shine_fill_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .pixel_in_i    (pixel_in_i),
    .column_i      (column_i),
    .row_offset_i  (row_offset_i),
    .done_o        (done_o),
    .pixel_out_o   (pixel_out_o),
    .write_pixel_o (write_pixel_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #4000000;
    $display("[masked_gradient_shine_fill_core] ERROR");
    $finish;
  end

  // floor(((d - t) * p + t * q) / d), exact
  function automatic int unsigned row_mix(int unsigned p, int unsigned q,
                                          int unsigned t, int unsigned d);
    return ((d - t) * p + t * q) / d;
  endfunction

  // Predicted result word for one pixel under the current register copy.
  function automatic fill_word_t gradient_pixel(logic [PIX_W-1:0] pix,
                                                logic [COL_W-1:0] col,
                                                logic [ROW_W-1:0] row);
    fill_word_t  w;
    int unsigned d, r, t, lo, hi, hue, luma, ad, glow, sum;
    int          sc, sdiff;
    hue_mode_e   mode;
    if (pix != mask_q) begin
      w.pixel = pix;
      w.wr    = 1'b0;
      return w;
    end
    // Height of one or zero: flat color_start on every row.
    if (height_q <= 1) begin
      d = 1;
      r = 0;
    end else begin
      d = height_q - 1;
      r = (row > d) ? d : row;   // rows past the bottom clamp to it
    end
    // Hue always blends from the smaller hue up; swapping flips the ratio.
    lo = color_start_q[7:4];
    hi = color_end_q[7:4];
    t  = r;
    if (color_start_q[7:4] > color_end_q[7:4]) begin
      lo = color_end_q[7:4];
      hi = color_start_q[7:4];
      t  = d - r;
    end
    if (lo == 0)
      mode = HUE_PLAIN;
    else if (hi - lo > HUE_SPAN)
      mode = HUE_WRAP;
    else
      mode = HUE_ADD1;
    case (mode)
      HUE_PLAIN: hue = row_mix(0, hi, t, d);
      HUE_WRAP:  hue = (row_mix(lo - 1 + HUE_RING, hi - 1, t, d) % HUE_RING) + 1;
      default:   hue = row_mix(lo - 1, hi - 1, t, d) + 1;
    endcase
    luma = row_mix(color_start_q[3:0], color_end_q[3:0], r, d) & LUMA_MAX;
    // Shine uses the raw row; its column may go negative.
    if (shine_q != 0) begin
      sc    = int'(shine_q) - ((int'(row) + int'(top_odd_q)) / 2);
      sdiff = sc - int'(col);
      if (sdiff < 0) sdiff = -sdiff;
      ad    = unsigned'(sdiff);
      glow  = glow_peak_q - ((ad < glow_peak_q) ? ad : glow_peak_q);
      sum   = luma + glow;
      luma  = (sum < LUMA_MAX) ? sum : LUMA_MAX;
    end
    w.pixel = {hue[3:0], luma[3:0]};
    w.wr    = 1'b1;
    return w;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one pixel word and hold it until taken. start stays high when the
  // next word follows right away, so the caller must send again or lower it
  // in the same step.
  task automatic send_pixel(logic [PIX_W-1:0] pix, logic [COL_W-1:0] col,
                            logic [ROW_W-1:0] row, bit typed, fill_word_t want);
    int unsigned gap;
    start        <= 1'b1;
    pixel_in_i   <= pix;
    column_i     <= col;
    row_offset_i <= row;
    do @(posedge clk_i); while (busy);
    pending_fills.push_back(typed ? want : gradient_pixel(pix, col, row));
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering words and wait for every outstanding result.
  task automatic drain_pixels();
    start <= 1'b0;
    while (pending_fills.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_COLOR_START: color_start_q = data[PIX_W-1:0];
      REG_COLOR_END:   color_end_q   = data[PIX_W-1:0];
      REG_MASK_COLOR:  mask_q        = data[PIX_W-1:0];
      REG_RECT_HEIGHT: height_q      = data[HGT_W-1:0];
      REG_TOP_ODD:     top_odd_q     = data[0];
      REG_SHINE_START: shine_q       = data[SHINE_W-1:0];
      REG_SHINE_INT:   glow_peak_q   = data[NIB_W-1:0];
      default: ;   // unused index, ignored by the core
    endcase
    repeat (1 + pick_gap()) @(posedge clk_i);
  endtask

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    stim_rows.push_back(s);
  endfunction

  function automatic void add_pix(logic [PIX_W-1:0] pix, logic [COL_W-1:0] col,
                                  logic [ROW_W-1:0] row, bit typed = 1'b0,
                                  logic [PIX_W-1:0] exp_pix = '0, logic exp_wr = 1'b0);
    stim_row_t s;
    s = '{default: '0};
    s.pix   = pix;
    s.col   = col;
    s.row   = row;
    s.typed = typed;
    s.want  = '{pixel: exp_pix, wr: exp_wr};
    stim_rows.push_back(s);
  endfunction

  // Random register setting for one phase; the first two are the extremes.
  task automatic program_phase(int unsigned phase);
    logic [CFG_DAT_W-1:0] cs, ce, mk, hg, od, sh, gp;
    int unsigned          pick;
    cs = 11'($urandom_range(0, 2047));
    ce = 11'($urandom_range(0, 2047));
    mk = 11'($urandom_range(0, 2047));
    od = 11'($urandom_range(0, 2047));
    gp = 11'($urandom_range(0, 2047));
    sh = ($urandom_range(0, 4) == 0) ? 11'd0 : 11'($urandom_range(1, 1100));
    pick = $urandom_range(0, 9);
    if (pick == 0)      hg = 11'($urandom_range(0, 2));
    else if (pick == 1) hg = 11'($urandom_range(1025, 2047));
    else if (pick < 4)  hg = 11'd1024;
    else                hg = 11'($urandom_range(2, 64));
    if (phase == 0) begin
      cs = 11'h0FF; ce = 11'h000; mk = 11'h0FF; hg = 11'd2047;
      od = 11'd1;   sh = 11'd2047; gp = 11'd15;
    end else if (phase == 1) begin
      cs = 11'h000; ce = 11'h0FF; mk = 11'h000; hg = 11'd1;
      od = 11'd0;   sh = 11'd0;    gp = 11'd0;
    end else if (phase == 2) begin
      hg = 11'd1024;
      sh = 11'd1023;
    end
    write_reg(REG_COLOR_START, cs);
    write_reg(REG_COLOR_END,   ce);
    write_reg(REG_MASK_COLOR,  mk);
    write_reg(REG_RECT_HEIGHT, hg);
    write_reg(REG_TOP_ODD,     od);
    write_reg(REG_SHINE_START, sh);
    write_reg(REG_SHINE_INT,   gp);
  endtask

  // Each strobe is taken at the edge that ends its cycle; compare against the
  // oldest prediction.
  always @(posedge clk_i) begin : result_check
    fill_word_t want;
    if (rst_ni && done_o) begin
      if (pending_fills.size() == 0) begin
        $error("result with nothing pending: pixel_out %h write_pixel %b",
               pixel_out_o, write_pixel_o);
        errors++;
      end else begin
        want = pending_fills.pop_front();
        if (pixel_out_o !== want.pixel) begin
          $error("pixel_out: expected %h, got %h", want.pixel, pixel_out_o);
          errors++;
        end
        if (write_pixel_o !== want.wr) begin
          $error("write_pixel: expected %b, got %b", want.wr, write_pixel_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    fill_word_t        none;
    logic [PIX_W-1:0]  pix;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    int unsigned       row_top;
    int                sc, c;

    none = '0;

    // Directed part. Reset state: mask 0, height 1, all black.
    add_pix(8'h00, 10'd0, 10'd0, 1'b1, 8'h00, 1'b1);
    add_pix(8'hFF, 10'd1023, 10'd1023, 1'b1, 8'hFF, 1'b0);
    // Upper data bits are dropped for the narrow registers.
    add_cfg(REG_COLOR_START, 11'h75A);
    add_cfg(REG_COLOR_END,   11'h03C);
    add_cfg(REG_MASK_COLOR,  11'h7AB);
    add_cfg(3'd7,            11'h7FF);    // unused index
    // Height one: color_start whatever the row.
    add_pix(8'hAB, 10'd5, 10'd700, 1'b1, 8'h5A, 1'b1);
    add_pix(8'hAA, 10'd5, 10'd5, 1'b1, 8'hAA, 1'b0);
    add_cfg(REG_RECT_HEIGHT, 11'd0);
    add_pix(8'hAB, 10'd1023, 10'd1023, 1'b1, 8'h5A, 1'b1);
    // Full height: top, bottom, middle.
    add_cfg(REG_RECT_HEIGHT, 11'd1024);
    add_pix(8'hAB, 10'd0, 10'd0);
    add_pix(8'hAB, 10'd0, 10'd1023);
    add_pix(8'hAB, 10'd512, 10'd511);
    // Row past the bottom clamps.
    add_cfg(REG_RECT_HEIGHT, 11'd9);
    add_pix(8'hAB, 10'd3, 10'd200);
    // White to a hue.
    add_cfg(REG_COLOR_START, 11'h00F);
    add_cfg(REG_COLOR_END,   11'h0C3);
    add_pix(8'hAB, 10'd0, 10'd4);
    // Wrap across hue 15, both directions.
    add_cfg(REG_COLOR_START, 11'h021);
    add_cfg(REG_COLOR_END,   11'h0E8);
    add_pix(8'hAB, 10'd0, 10'd4);
    add_pix(8'hAB, 10'd0, 10'd8);
    add_cfg(REG_COLOR_START, 11'h0E0);
    add_cfg(REG_COLOR_END,   11'h02F);
    add_pix(8'hAB, 10'd0, 10'd2);
    // Short way, start hue above end hue.
    add_cfg(REG_COLOR_START, 11'h052);
    add_cfg(REG_COLOR_END,   11'h037);
    add_pix(8'hAB, 10'd0, 10'd5);
    // Shine: column goes negative, then a direct hit that saturates.
    add_cfg(REG_SHINE_INT,   11'h7FF);
    add_cfg(REG_TOP_ODD,     11'h7FF);
    add_cfg(REG_SHINE_START, 11'd3);
    add_pix(8'hAB, 10'd0, 10'd20);
    add_pix(8'hAB, 10'd2, 10'd2);
    add_cfg(REG_SHINE_START, 11'd2047);
    add_pix(8'hAB, 10'd1023, 10'd0);
    add_cfg(REG_TOP_ODD,     11'd0);
    add_cfg(REG_SHINE_START, 11'd600);
    add_pix(8'hAB, 10'd595, 10'd10);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        drain_pixels();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_pixel(stim_rows[i].pix, stim_rows[i].col, stim_rows[i].row,
                   stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random part: ten settings, forty words each.
    for (int unsigned phase = 0; phase < 10; phase++) begin
      drain_pixels();
      burst = 1'b0;
      program_phase(phase);
      burst = ($urandom_range(0, 3) == 0);
      row_top = (height_q > 1) ? height_q - 1 : 0;
      if (row_top > 1023) row_top = 1023;
      for (int k = 0; k < 40; k++) begin
        pix = ($urandom_range(0, 99) < 65) ? mask_q : 8'($urandom_range(0, 255));
        row = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, row_top));
        col = 10'($urandom_range(0, 1023));
        // Half the words land near the shine column so the glow shows up.
        if (shine_q != 0 && $urandom_range(0, 1) == 1) begin
          sc = int'(shine_q) - ((int'(row) + int'(top_odd_q)) / 2);
          c  = sc + int'($urandom_range(0, 32)) - 16;
          if (c >= 0 && c <= 1023) col = 10'(c);
        end
        send_pixel(pix, col, row, 1'b0, none);
        // Now and then let the pipeline run dry before the next word.
        if ($urandom_range(0, 99) < 2) drain_pixels();
      end
    end

    drain_pixels();
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("[masked_gradient_shine_fill_core] OK");
    end else begin
      $display("[masked_gradient_shine_fill_core] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mgsf_pkg.sv
rtl/masked_gradient_shine_fill_core.sv
rtl/mgsf_checker.sv
dv/masked_gradient_shine_fill_core_test.sv
